@@ rtl/core/modular_exponentiation_macros.svh @@
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define MX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define MX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp assertion failed");
`else
`define MX_ASSERT_IMP(lbl, ante, cons)
`define MX_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/modexp_pkg.sv @@
// package for the modular exponentiation block: widths, microcode and modular step
`default_nettype none

package modexp_pkg;

    localparam int MOD_W    = 30;
    localparam int BASE_W   = 31;
    localparam int EXP_IN_W = 63;
    localparam int EXP_BITS = 63;
    localparam int CNT_W    = $clog2(BASE_W);
    localparam int PC_W     = 3;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_ZCHK = 3'd1;
    localparam logic [PC_W-1:0] PC_REDB = 3'd2;
    localparam logic [PC_W-1:0] PC_TEST = 3'd3;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd4;
    localparam logic [PC_W-1:0] PC_UPD  = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd7;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_NOP,
        OP_REDB,
        OP_PREP,
        OP_MUL,
        OP_UPD,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_IN,
        C_MZERO,
        C_CNT_NZ,
        C_EZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        case (pc)
            PC_IDLE: w = '{op: OP_IDLE, cond: C_NO_IN,    target: PC_IDLE};
            PC_ZCHK: w = '{op: OP_NOP,  cond: C_MZERO,    target: PC_EMIT};
            PC_REDB: w = '{op: OP_REDB, cond: C_CNT_NZ,   target: PC_REDB};
            PC_TEST: w = '{op: OP_PREP, cond: C_EZERO,    target: PC_EMIT};
            PC_MUL:  w = '{op: OP_MUL,  cond: C_CNT_NZ,   target: PC_MUL};
            PC_UPD:  w = '{op: OP_UPD,  cond: C_ALWAYS,   target: PC_TEST};
            PC_EMIT: w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: PC_EMIT};
            default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

    // one radix-2 step: (2r + in_bit + addend) mod m, for r < m and addend < m
    function automatic logic [MOD_W-1:0] mod_step(
        input logic [MOD_W-1:0] r,
        input logic             in_bit,
        input logic [MOD_W-1:0] addend,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] mw;
        logic [MOD_W:0] t;
        logic [MOD_W:0] u;
        mw = {1'b0, m};
        t  = {r, in_bit};
        if (t >= mw)
        begin
            t = t - mw;
        end
        u = {1'b0, t[MOD_W-1:0]} + {1'b0, addend};
        if (u >= mw)
        begin
            u = u - mw;
        end
        return u[MOD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/modular_exponentiation.sv @@
// modular exponentiation top level: microcoded square-and-multiply sequencer
// after a word is taken: zero-modulus check, base reduction, then for each exponent bit up to
//   the highest set one a test, the multiply lanes and an update, then the emit step
// the multiply lanes are 30-step bit-serial modular multiplies, one product bit per cycle
// one word in flight; the next is taken while the result waits
// reset: modulus returns to 1000000007, sequencer to idle, no result pending
`default_nettype none

`include "modular_exponentiation_macros.svh"

module modular_exponentiation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input word channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic [modexp_pkg::BASE_W-1:0]   base,
    input  wire logic [modexp_pkg::EXP_IN_W-1:0] exponent,
    // result word channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [modexp_pkg::MOD_W-1:0]         result,
    // modulus write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [modexp_pkg::MOD_W-1:0]    cfg_data
);

    // sequencer
    logic [modexp_pkg::PC_W-1:0]  pc_reg, pc_next;
    modexp_pkg::ctl_word_t        ctl;
    logic                         cond_hit;

    // datapath registers
    logic [modexp_pkg::MOD_W-1:0]    modulus_reg;
    logic [modexp_pkg::MOD_W-1:0]    acc_reg, acc_next;     // running result
    logic [modexp_pkg::MOD_W-1:0]    sq_reg, sq_next;       // running power of the base
    logic [modexp_pkg::MOD_W-1:0]    ta_reg, ta_next;       // acc * sq partial
    logic [modexp_pkg::MOD_W-1:0]    tb_reg, tb_next;       // sq * sq partial
    logic [modexp_pkg::MOD_W-1:0]    sha_reg, sha_next;     // multiplier bits of acc
    logic [modexp_pkg::MOD_W-1:0]    shb_reg, shb_next;     // multiplier bits of sq
    logic [modexp_pkg::BASE_W-1:0]   bsh_reg, bsh_next;     // base bits, msb first
    logic [modexp_pkg::EXP_BITS-1:0] e_reg, e_next;         // exponent, lsb first
    logic [modexp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [modexp_pkg::MOD_W-1:0]    result_reg;
    logic                            out_valid_reg;

    // handshake helpers
    logic in_fire;
    logic out_free;
    logic emit_fire;

    // inverse exponent: modulus - 2, or 0 for moduli below two
    logic [modexp_pkg::MOD_W-1:0]                    m_minus2;
    logic [modexp_pkg::EXP_BITS-1:0]                 inv_exp;
    logic                                            m_small;

    assign ctl       = modexp_pkg::ucode(pc_reg);
    assign in_stall  = (ctl.op != modexp_pkg::OP_IDLE);
    // no modulus write at the edge that takes a new word
    assign cfg_ready = (ctl.op == modexp_pkg::OP_IDLE) && !in_valid;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (ctl.op == modexp_pkg::OP_EMIT) && out_free;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign m_small  = (modulus_reg < modexp_pkg::MOD_W'(2));
    assign m_minus2 = modulus_reg - modexp_pkg::MOD_W'(2);
    assign inv_exp  = m_small ? '0 : modexp_pkg::EXP_BITS'(m_minus2);

    // branch condition and next program address
    always_comb
    begin
        case (ctl.cond)
            modexp_pkg::C_ALWAYS:   cond_hit = 1'b1;
            modexp_pkg::C_NO_IN:    cond_hit = !in_valid;
            modexp_pkg::C_MZERO:    cond_hit = (modulus_reg == '0);
            modexp_pkg::C_CNT_NZ:   cond_hit = (cnt_reg != '0);
            modexp_pkg::C_EZERO:    cond_hit = (e_reg == '0);
            modexp_pkg::C_OUT_BUSY: cond_hit = !out_free;
            default:                cond_hit = 1'b0;
        endcase
        // fall-through from the emit word wraps to idle
        pc_next = cond_hit ? ctl.target : pc_reg + modexp_pkg::PC_W'(1);
    end

    // datapath next values, one micro-op per cycle
    always_comb
    begin
        acc_next = acc_reg;
        sq_next  = sq_reg;
        ta_next  = ta_reg;
        tb_next  = tb_reg;
        sha_next = sha_reg;
        shb_next = shb_reg;
        bsh_next = bsh_reg;
        e_next   = e_reg;
        cnt_next = cnt_reg;
        case (ctl.op)
            modexp_pkg::OP_IDLE:
            begin
                if (in_fire)
                begin
                    bsh_next = base;
                    sq_next  = '0;
                    e_next   = opcode ? inv_exp : exponent[modexp_pkg::EXP_BITS-1:0];
                    // 1 mod m: zero for moduli of zero or one
                    acc_next = m_small ? '0 : modexp_pkg::MOD_W'(1);
                    cnt_next = modexp_pkg::CNT_W'(modexp_pkg::BASE_W - 1);
                end
            end
            modexp_pkg::OP_REDB:
            begin
                // reduce the raw base into sq, one bit a cycle
                sq_next  = modexp_pkg::mod_step(sq_reg, bsh_reg[modexp_pkg::BASE_W-1],
                                                '0, modulus_reg);
                bsh_next = {bsh_reg[modexp_pkg::BASE_W-2:0], 1'b0};
                cnt_next = cnt_reg - modexp_pkg::CNT_W'(1);
            end
            modexp_pkg::OP_PREP:
            begin
                ta_next  = '0;
                tb_next  = '0;
                sha_next = acc_reg;
                shb_next = sq_reg;
                cnt_next = modexp_pkg::CNT_W'(modexp_pkg::MOD_W - 1);
            end
            modexp_pkg::OP_MUL:
            begin
                // both products share the old sq, so they run side by side
                ta_next  = modexp_pkg::mod_step(ta_reg, 1'b0,
                               sha_reg[modexp_pkg::MOD_W-1] ? sq_reg : '0, modulus_reg);
                tb_next  = modexp_pkg::mod_step(tb_reg, 1'b0,
                               shb_reg[modexp_pkg::MOD_W-1] ? sq_reg : '0, modulus_reg);
                sha_next = {sha_reg[modexp_pkg::MOD_W-2:0], 1'b0};
                shb_next = {shb_reg[modexp_pkg::MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg - modexp_pkg::CNT_W'(1);
            end
            modexp_pkg::OP_UPD:
            begin
                if (e_reg[0])
                begin
                    acc_next = ta_reg;
                end
                sq_next = tb_reg;
                e_next  = e_reg >> 1;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= modexp_pkg::PC_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= modexp_pkg::MOD_RESET;
        end
        else
        begin
            pc_reg <= pc_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        ta_reg  <= ta_next;
        tb_reg  <= tb_next;
        sha_reg <= sha_next;
        shb_reg <= shb_next;
        bsh_reg <= bsh_next;
        e_reg   <= e_next;
        cnt_reg <= cnt_next;
        if (emit_fire)
        begin
            result_reg <= acc_reg;
        end
    end

    // operands stay reduced while the multiply lanes run
    `MX_ASSERT_IMP(a_operands_reduced,
        (ctl.op == modexp_pkg::OP_MUL) && (modulus_reg != '0),
        (sq_reg < modulus_reg) && (acc_reg < modulus_reg))
    // each update consumes exactly one exponent bit
    `MX_ASSERT_NXT(a_exp_shift,
        ctl.op == modexp_pkg::OP_UPD,
        e_reg == ($past(e_reg) >> 1))
    // a new result word only ever comes from the emit step
    `MX_ASSERT_IMP(a_result_from_emit,
        $rose(out_valid_reg),
        $past(pc_reg) == modexp_pkg::PC_EMIT)

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the modular exponentiation block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode field values
    localparam logic OPC_POWER   = 1'b0;
    localparam logic OPC_INVERSE = 1'b1;

    // number of mismatches reported in full, later ones only counted
    localparam int unsigned REPORT_LIMIT = 10;
    // settle time at the end of the run, longer than the slowest word takes
    localparam int unsigned SETTLE_CYCLES = 2100;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_WORDS   = 50;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             opcode;
    logic [modexp_pkg::BASE_W-1:0]    base;
    logic [modexp_pkg::EXP_IN_W-1:0]  exponent;
    logic                             out_valid;
    logic                             out_stall;
    logic [modexp_pkg::MOD_W-1:0]     result;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [modexp_pkg::MOD_W-1:0]     cfg_data;

    // powers still owed by the block, oldest first
    logic [modexp_pkg::MOD_W-1:0]     pending_powers[$];
    // our own copy of the modulus register
    logic [modexp_pkg::MOD_W-1:0]     modulus_shadow = modexp_pkg::MOD_RESET;
    int unsigned                      mismatch_count = 0;
    // idling switches, so that some phases run with no gaps at all
    bit                               input_gaps_on  = 1'b1;
    bit                               stall_on       = 1'b1;

    always #6 clk = ~clk;

    modular_exponentiation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // right-to-left square and multiply, every product reduced
    // a zero modulus gives 0; the inverse uses modulus - 2 (or 0 for modulus 1)
    function automatic logic [modexp_pkg::MOD_W-1:0] mod_power(
        input logic                            op,
        input logic [modexp_pkg::BASE_W-1:0]   b,
        input logic [modexp_pkg::EXP_IN_W-1:0] e,
        input logic [modexp_pkg::MOD_W-1:0]    m
    );
        logic [63:0] m64;
        logic [63:0] ex;
        logic [63:0] acc;
        logic [63:0] sq;
        if (m == '0)
        begin
            return '0;
        end
        m64 = 64'(m);
        ex  = 64'(e);
        if (op == OPC_INVERSE)
        begin
            ex = (m64 >= 64'd2) ? m64 - 64'd2 : 64'd0;
        end
        acc = 64'd1 % m64;
        sq  = 64'(b) % m64;
        for (int i = 0; i < modexp_pkg::EXP_BITS; i++)
        begin
            if (ex[i])
            begin
                acc = (acc * sq) % m64;
            end
            sq = (sq * sq) % m64;
        end
        return acc[modexp_pkg::MOD_W-1:0];
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic void note_mismatch(
        input string                        what,
        input logic [modexp_pkg::MOD_W-1:0] want,
        input logic [modexp_pkg::MOD_W-1:0] got
    );
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // sends one word; the expected power is queued when the word is taken
    task automatic send_word(
        input logic                            op,
        input logic [modexp_pkg::BASE_W-1:0]   b,
        input logic [modexp_pkg::EXP_IN_W-1:0] e
    );
        int unsigned gap;
        gap = input_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        base     <= b;
        exponent <= e;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_powers = {pending_powers, mod_power(op, b, e, modulus_shadow)};
    endtask

    // drops valid and waits until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_powers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // modulus write, only while the block is idle
    task automatic write_modulus(input logic [modexp_pkg::MOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid      <= 1'b0;
        modulus_shadow  = value;
        @(posedge clk);
    endtask

    // modulus left at its reset value: zero exponent, unreduced and
    // multiple-of-modulus bases, inverse of zero, top exponent bit
    task automatic test_reset_modulus();
        send_word(OPC_POWER,   31'd0,          63'd0);
        send_word(OPC_POWER,   31'd2,          63'd10);
        send_word(OPC_POWER,   {modexp_pkg::BASE_W{1'b1}}, {modexp_pkg::EXP_IN_W{1'b1}});
        send_word(OPC_POWER,   31'd2000000014, 63'd5);
        send_word(OPC_POWER,   {modexp_pkg::BASE_W{1'b1}}, 63'd3);
        send_word(OPC_POWER,   31'd3,          63'd1 << 62);
        send_word(OPC_INVERSE, 31'd2,          63'd0);
        send_word(OPC_INVERSE, 31'd0,          63'd77);
        send_word(OPC_INVERSE, 31'd2000000014, {modexp_pkg::EXP_IN_W{1'b1}});
        send_word(OPC_INVERSE, {modexp_pkg::BASE_W{1'b1}}, 63'd1);
        drain_results();
    endtask

    // modulus of one, of two, the largest, and the meaningless zero
    task automatic test_modulus_extremes();
        write_modulus(30'd1);
        send_word(OPC_POWER,   31'd5, 63'd7);
        send_word(OPC_POWER,   31'd0, 63'd0);
        send_word(OPC_INVERSE, 31'd5, 63'd9);
        drain_results();
        write_modulus({modexp_pkg::MOD_W{1'b1}});
        send_word(OPC_POWER,   {modexp_pkg::BASE_W{1'b1}}, {modexp_pkg::EXP_IN_W{1'b1}});
        send_word(OPC_INVERSE, 31'd12345,      63'd0);
        drain_results();
        write_modulus(30'd2);
        send_word(OPC_INVERSE, 31'd3, 63'd0);
        send_word(OPC_POWER,   31'd0, 63'd0);
        drain_results();
        write_modulus(30'd0);
        send_word(OPC_POWER,   31'd7, 63'd3);
        send_word(OPC_INVERSE, 31'd7, 63'd0);
        drain_results();
    endtask

    // random words over several modulus settings; exponents mostly short
    // so the run stays fast, a few full width so every bit toggles
    task automatic test_random_words();
        logic [modexp_pkg::MOD_W-1:0]    m;
        logic                            op;
        logic [modexp_pkg::BASE_W-1:0]   b;
        logic [63:0]                     e;
        longint unsigned                 k;
        int unsigned                     r;
        int unsigned                     w;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       m = modexp_pkg::MOD_RESET;
                1:       m = {modexp_pkg::MOD_W{1'b1}};
                2:       m = modexp_pkg::MOD_W'($urandom_range(2, 200));
                3:       m = 30'd65537;
                4:       m = modexp_pkg::MOD_W'($urandom_range(1,
                                 (1 << modexp_pkg::MOD_W) - 1));
                5:       m = 30'd1 << 29;
                6:       m = 30'd1;
                default: m = modexp_pkg::MOD_W'($urandom_range(1000,
                                 (1 << modexp_pkg::MOD_W) - 1));
            endcase
            write_modulus(m);
            // one phase in four runs flat out on both sides
            input_gaps_on = (phase % 4) != 2;
            stall_on      = (phase % 4) != 2;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                op = ($urandom_range(0, 99) < 30) ? OPC_INVERSE : OPC_POWER;
                r  = $urandom_range(0, 99);
                if (r < 70)
                begin
                    b = modexp_pkg::BASE_W'($urandom());
                end
                else if (r < 80)
                begin
                    b = modexp_pkg::BASE_W'($urandom_range(0, 20));
                end
                else if (r < 90 && m != '0)
                begin
                    // multiple of the modulus
                    k = 64'(m) * $urandom_range(1, ((1 << modexp_pkg::BASE_W) - 1) / m);
                    b = modexp_pkg::BASE_W'(k);
                end
                else
                begin
                    b = {modexp_pkg::BASE_W{1'b1}};
                end
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    w = $urandom_range(0, 16);
                end
                else if (r < 90)
                begin
                    w = $urandom_range(17, 62);
                end
                else
                begin
                    w = modexp_pkg::EXP_IN_W;
                end
                e = {$urandom(), $urandom()} & ((64'd1 << w) - 64'd1);
                send_word(op, b, e[modexp_pkg::EXP_IN_W-1:0]);
            end
            drain_results();
        end
        input_gaps_on = 1'b1;
        stall_on      = 1'b1;
    endtask

    // result side: random stall bursts, released between bursts
    initial
    begin : stall_gen
        int unsigned hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
            end
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end
            else if (stall_on)
            begin
                hold = pick_gap();
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    hold = hold - 1;
                end
            end
        end
    end

    // each accepted result word is checked against the oldest owed power
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_powers.size() == 0)
            begin
                note_mismatch("result word with nothing owed", '0, result);
            end
            else if (result !== pending_powers[0])
            begin
                note_mismatch("result mismatch", pending_powers[0], result);
                void'(pending_powers.pop_front());
            end
            else
            begin
                void'(pending_powers.pop_front());
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OPC_POWER;
        base      <= '0;
        exponent  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_random_words();

        // give a stray word time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_powers.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard: several times the slowest legal run
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/modexp_pkg.sv
rtl/core/modular_exponentiation.sv
sim/testbench.sv
